[hw/rtl/htk_pkg.sv]
// ----------------------------------------------------------------------------
// htk_pkg
// Shared types, character codes and token class codes of the HTTP message head
// tokenizer.
// ----------------------------------------------------------------------------
package htk_pkg;

	localparam int LEN_BITS   = 32;
	localparam int BYTE_W     = 8;
	localparam int CLASS_W    = 4;
	localparam int KIND_W     = 2;
	localparam int LEN_OUT_W  = 32;
	localparam int NAME_LEN   = 14;
	localparam int POS_W      = 4;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [CLASS_W-1:0]   class_t;
	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [LEN_BITS-1:0]  len_t;
	typedef logic [LEN_OUT_W-1:0] len_out_t;
	typedef logic [POS_W-1:0]     pos_t;

	// token classes
	localparam class_t CLS_DROPPED = 4'd0;
	localparam class_t CLS_FIRST   = 4'd1;
	localparam class_t CLS_METHOD  = 4'd2;
	localparam class_t CLS_URI     = 4'd3;
	localparam class_t CLS_VERSION = 4'd4;
	localparam class_t CLS_STATUS  = 4'd5;
	localparam class_t CLS_REASON  = 4'd6;
	localparam class_t CLS_NAME    = 4'd7;
	localparam class_t CLS_VALUE   = 4'd8;
	localparam class_t CLS_BODY    = 4'd9;

	// message kinds
	localparam kind_t KIND_UNDECIDED = 2'd0;
	localparam kind_t KIND_REQUEST   = 2'd1;
	localparam kind_t KIND_RESPONSE  = 2'd2;

	// delimiters
	localparam byte_t CH_SP    = 8'h20;
	localparam byte_t CH_SLASH = 8'h2F;
	localparam byte_t CH_COLON = 8'h3A;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_LF    = 8'h0A;

	// parser modes, one-hot
	typedef enum logic [10:0] {
		MODE_FIRST   = 11'b000_0000_0001,
		MODE_URI     = 11'b000_0000_0010,
		MODE_REQVER  = 11'b000_0000_0100,
		MODE_RESPVER = 11'b000_0000_1000,
		MODE_STATUS  = 11'b000_0001_0000,
		MODE_REASON  = 11'b000_0010_0000,
		MODE_HDRSEP  = 11'b000_0100_0000,
		MODE_NAME    = 11'b000_1000_0000,
		MODE_VALUE   = 11'b001_0000_0000,
		MODE_SEP     = 11'b010_0000_0000,
		MODE_BODY    = 11'b100_0000_0000
	} mode_t;

	// characters of the header name Content-Length
	function automatic byte_t cl_name_char(input pos_t pos);
		byte_t c;
		case (pos)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h4C; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/htk_byte_if.sv]
// ----------------------------------------------------------------------------
// htk_byte_if
// Valid/ready channel carrying one raw byte of the message stream.
// ----------------------------------------------------------------------------
interface htk_byte_if;
	logic           valid;
	logic           ready;
	htk_pkg::byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

[hw/rtl/htk_token_if.sv]
// ----------------------------------------------------------------------------
// htk_token_if
// Valid/ready channel carrying one tagged byte with the parser status.
// ----------------------------------------------------------------------------
interface htk_token_if;
	logic              valid;
	logic              ready;
	htk_pkg::class_t   token_class;
	htk_pkg::byte_t    out_byte;
	logic              token_end;
	htk_pkg::kind_t    message_kind;
	logic              head_done;
	htk_pkg::len_out_t length_value;
	logic              length_seen;
	logic              format_error;

	modport source (
		output valid, output token_class, output out_byte, output token_end,
		output message_kind, output head_done, output length_value,
		output length_seen, output format_error, input ready
	);
	modport sink (
		input valid, input token_class, input out_byte, input token_end,
		input message_kind, input head_done, input length_value,
		input length_seen, input format_error, output ready
	);
endinterface

[hw/rtl/http_message_head_tokenizer.sv]
// ----------------------------------------------------------------------------
// http_message_head_tokenizer
// Tags each byte of an HTTP/1.1 message with its token class and tracks
// Content-Length.
// ----------------------------------------------------------------------------
// One byte per clock, sustained while the token sink keeps ready high. Each byte
// is taken into an input register, classified combinationally by the parser
// state machine, and then captured in the result register, which drives the
// token transaction. The two registers form a short
// pipeline that only stalls when the token sink holds ready low; while a
// finished result waits, one more byte is still taken if the input register is
// empty, and after that the stream is held off until the result is drained.
// The first token sets the message kind (space: request, slash:
// response). Header values of an exact, case-sensitive Content-Length name are
// accumulated as a saturating decimal number; non-digits raise format_error and
// leave the value unchanged. head_done marks the LF of the empty line. Body bytes
// are tagged only when a nonzero Content-Length was seen; there is no
// count-down, so every byte after the head is treated as body.
// ----------------------------------------------------------------------------
module http_message_head_tokenizer (
	input  logic          clk,
	input  logic          arst_n,
	htk_byte_if.sink      stream,
	htk_token_if.source   tokens
);

	localparam int ACC_W = htk_pkg::LEN_BITS + 4;

	// input register
	logic           valid_s1;
	htk_pkg::byte_t byte_s1;

	// result register
	logic              valid_s2;
	htk_pkg::class_t   class_s2;
	htk_pkg::byte_t    byte_s2;
	logic              tend_s2;
	htk_pkg::kind_t    kind_s2;
	logic              hdone_s2;
	htk_pkg::len_out_t lenv_s2;
	logic              seen_s2;
	logic              ferr_s2;

	// parser state
	htk_pkg::mode_t mode_q;
	htk_pkg::kind_t kind_q;
	htk_pkg::pos_t  pos_q;
	logic           mismatch_q;
	logic           started_q;
	logic           in_len_q;
	htk_pkg::len_t  accum_q;
	logic           flag_q;
	logic           closed_q;

	// next state and result
	htk_pkg::mode_t    mode_d;
	htk_pkg::kind_t    kind_d;
	htk_pkg::pos_t     pos_d;
	logic              mismatch_d;
	logic              started_d;
	logic              in_len_d;
	htk_pkg::len_t     accum_d;
	logic              flag_d;
	logic              closed_d;
	htk_pkg::class_t   cls;
	logic              tend;
	logic              hdone;
	logic              ferr;
	htk_pkg::mode_t    eff_mode;
	logic [ACC_W-1:0]  acc_ext;
	logic [ACC_W-1:0]  times10;
	logic [63:0]       accum_wide;
	htk_pkg::len_out_t lenv;

	logic advance;
	logic step;

	// Move the result register whenever it is empty or being drained.
	assign advance      = !valid_s2 || tokens.ready;
	assign stream.ready = !valid_s1 || advance;
	assign step         = valid_s1 && advance;

	// Saturating decimal step: accum * 10 + digit, in four extra bits.
	assign acc_ext = ACC_W'(accum_q);
	assign times10 = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(byte_s1[3:0]);

	always_comb begin
		mode_d     = mode_q;
		kind_d     = kind_q;
		pos_d      = pos_q;
		mismatch_d = mismatch_q;
		started_d  = started_q;
		in_len_d   = in_len_q;
		accum_d    = accum_q;
		flag_d     = flag_q;
		closed_d   = closed_q;
		cls        = htk_pkg::CLS_DROPPED;
		tend       = 1'b0;
		hdone      = 1'b0;
		ferr       = 1'b0;
		eff_mode   = mode_q;

		// After a header line: CR opens the empty line, anything else starts a name.
		if (mode_q == htk_pkg::MODE_HDRSEP) begin
			if (byte_s1 == htk_pkg::CH_CR) begin
				mode_d   = htk_pkg::MODE_SEP;
				eff_mode = htk_pkg::MODE_HDRSEP;
			end else begin
				eff_mode   = htk_pkg::MODE_NAME;
				mode_d     = htk_pkg::MODE_NAME;
				pos_d      = '0;
				mismatch_d = 1'b0;
			end
		end

		case (eff_mode)
			htk_pkg::MODE_HDRSEP: begin
				// CR of the empty line: dropped, nothing else to do
			end
			htk_pkg::MODE_FIRST: begin
				if (byte_s1 == htk_pkg::CH_SP) begin
					cls    = htk_pkg::CLS_METHOD;
					tend   = 1'b1;
					kind_d = htk_pkg::KIND_REQUEST;
					mode_d = htk_pkg::MODE_URI;
				end else if (byte_s1 == htk_pkg::CH_SLASH) begin
					// the slash already belongs to the version token
					cls    = htk_pkg::CLS_VERSION;
					kind_d = htk_pkg::KIND_RESPONSE;
					mode_d = htk_pkg::MODE_RESPVER;
				end else begin
					cls = htk_pkg::CLS_FIRST;
				end
			end
			htk_pkg::MODE_URI: begin
				cls = htk_pkg::CLS_URI;
				if (byte_s1 == htk_pkg::CH_SP) begin
					tend   = 1'b1;
					mode_d = htk_pkg::MODE_REQVER;
				end
			end
			htk_pkg::MODE_RESPVER: begin
				cls = htk_pkg::CLS_VERSION;
				if (byte_s1 == htk_pkg::CH_SP) begin
					tend   = 1'b1;
					mode_d = htk_pkg::MODE_STATUS;
				end
			end
			htk_pkg::MODE_STATUS: begin
				cls = htk_pkg::CLS_STATUS;
				if (byte_s1 == htk_pkg::CH_SP) begin
					tend   = 1'b1;
					mode_d = htk_pkg::MODE_REASON;
				end
			end
			htk_pkg::MODE_REQVER, htk_pkg::MODE_REASON: begin
				if (byte_s1 == htk_pkg::CH_LF) begin
					closed_d = 1'b0;
					mode_d   = htk_pkg::MODE_HDRSEP;
				end else if (!closed_q) begin
					cls = (eff_mode == htk_pkg::MODE_REQVER) ?
						htk_pkg::CLS_VERSION : htk_pkg::CLS_REASON;
					if (byte_s1 == htk_pkg::CH_CR) begin
						tend     = 1'b1;
						closed_d = 1'b1;
					end
				end
			end
			htk_pkg::MODE_NAME: begin
				cls = htk_pkg::CLS_NAME;
				if (byte_s1 == htk_pkg::CH_COLON) begin
					tend      = 1'b1;
					mode_d    = htk_pkg::MODE_VALUE;
					started_d = 1'b0;
					closed_d  = 1'b0;
					in_len_d  = !mismatch_d && (pos_d == htk_pkg::pos_t'(htk_pkg::NAME_LEN));
					if (in_len_d) begin
						accum_d = '0;
					end
				end else if ((pos_d < htk_pkg::pos_t'(htk_pkg::NAME_LEN)) &&
						(byte_s1 == htk_pkg::cl_name_char(pos_d))) begin
					pos_d = pos_d + 1'b1;
				end else begin
					mismatch_d = 1'b1;
				end
			end
			htk_pkg::MODE_VALUE: begin
				if (byte_s1 == htk_pkg::CH_LF) begin
					// abandon an unclosed value
					closed_d = 1'b0;
					in_len_d = 1'b0;
					mode_d   = htk_pkg::MODE_HDRSEP;
				end else if (closed_q) begin
					cls = htk_pkg::CLS_DROPPED;
				end else if (byte_s1 == htk_pkg::CH_CR) begin
					cls      = htk_pkg::CLS_VALUE;
					tend     = 1'b1;
					closed_d = 1'b1;
					if (in_len_q) begin
						flag_d   = 1'b1;
						in_len_d = 1'b0;
					end
				end else if (!started_q && byte_s1 == htk_pkg::CH_SP) begin
					cls = htk_pkg::CLS_DROPPED;
				end else begin
					cls       = htk_pkg::CLS_VALUE;
					started_d = 1'b1;
					if (in_len_q) begin
						if (byte_s1 inside {[8'h30:8'h39]}) begin
							if (times10[ACC_W-1:htk_pkg::LEN_BITS] != '0) begin
								accum_d = '1;
							end else begin
								accum_d = times10[htk_pkg::LEN_BITS-1:0];
							end
						end else begin
							ferr = 1'b1;
						end
					end
				end
			end
			htk_pkg::MODE_SEP: begin
				if (byte_s1 == htk_pkg::CH_LF) begin
					hdone  = 1'b1;
					mode_d = htk_pkg::MODE_BODY;
				end else begin
					ferr = 1'b1;
				end
			end
			htk_pkg::MODE_BODY: begin
				cls = (flag_q && accum_q != '0) ? htk_pkg::CLS_BODY : htk_pkg::CLS_DROPPED;
			end
			default: begin
				mode_d = htk_pkg::MODE_FIRST;
			end
		endcase
	end

	// Show the accumulated length clipped to the output width.
	assign accum_wide = 64'(accum_d);
	assign lenv = (accum_wide[63:htk_pkg::LEN_OUT_W] != '0) ? '1 :
		accum_wide[htk_pkg::LEN_OUT_W-1:0];

	// Input register: hold while the pipeline stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
	end

	// Parser state advances once per byte leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= htk_pkg::MODE_FIRST;
			kind_q     <= htk_pkg::KIND_UNDECIDED;
			pos_q      <= '0;
			mismatch_q <= 1'b0;
			started_q  <= 1'b0;
			in_len_q   <= 1'b0;
			accum_q    <= '0;
			flag_q     <= 1'b0;
			closed_q   <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_d;
			kind_q     <= kind_d;
			pos_q      <= pos_d;
			mismatch_q <= mismatch_d;
			started_q  <= started_d;
			in_len_q   <= in_len_d;
			accum_q    <= accum_d;
			flag_q     <= flag_d;
			closed_q   <= closed_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			class_s2 <= cls;
			byte_s2  <= byte_s1;
			tend_s2  <= tend;
			kind_s2  <= kind_d;
			hdone_s2 <= hdone;
			lenv_s2  <= lenv;
			seen_s2  <= flag_d;
			ferr_s2  <= ferr;
		end
	end

	assign tokens.valid        = valid_s2;
	assign tokens.token_class  = class_s2;
	assign tokens.out_byte     = byte_s2;
	assign tokens.token_end    = tend_s2;
	assign tokens.message_kind = kind_s2;
	assign tokens.head_done    = hdone_s2;
	assign tokens.length_value = lenv_s2;
	assign tokens.length_seen  = seen_s2;
	assign tokens.format_error = ferr_s2;

	// Once decided, the message kind never changes.
	a_kind_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != htk_pkg::KIND_UNDECIDED) |=> (kind_q == $past(kind_q)))
		else $error("message kind changed after it was decided");

	// A delimiter always carries the class of the token it closes.
	a_end_classed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && tend_s2) |-> (class_s2 != htk_pkg::CLS_DROPPED))
		else $error("token end on a dropped byte");

	// Format errors arise only in a header value or after the final CR.
	a_ferr_place: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ferr_s2) |->
			(class_s2 == htk_pkg::CLS_VALUE || class_s2 == htk_pkg::CLS_DROPPED))
		else $error("format error on an unexpected token class");

	// An empty result register never blocks the stream.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> stream.ready)
		else $error("stream stalled with an empty result register");

endmodule
